[src/mrzv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MRZ validator package
// Shared types, constants and character helpers for the MRZ check-digit
// validator.
// ----------------------------------------------------------------------------
package mrzv_pkg;

	localparam int unsigned LineLength = 30;
	localparam logic [7:0] Filler = 8'h3C;
	localparam logic [5:0] FieldScore = 6'd15;
	localparam int unsigned NumFields = 4;

	// Field slots used for sums and flags.
	localparam int unsigned FldDocument  = 0;
	localparam int unsigned FldBirth     = 1;
	localparam int unsigned FldExpiry    = 2;
	localparam int unsigned FldComposite = 3;

	// One classified character, handed from the front to the back.
	typedef struct packed {
		logic [7:0]                 ch;        // corrected character
		logic [3:0]                 val;       // character value modulo 10
		logic                       is_digit;
		logic                       last;
		logic [NumFields-1:0]       acc_en;    // add to this field's sum
		logic [NumFields-1:0]       acc_rst;   // first position of the field
		logic [NumFields-1:0][2:0]  weight;
		logic [NumFields-1:0]       chk;       // check position of the field
	} mrzv_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mrzv_qstat_t;

	function automatic logic [7:0] fix_char(input logic [7:0] c);
		logic [7:0] u;
		logic [7:0] r;
		u = c;
		if (c >= "a" && c <= "z") begin
			u = c - 8'd32;
		end
		unique case (u)
			"O", "D", "Q": r = "0";
			"I":           r = "1";
			"S":           r = "5";
			"B":           r = "8";
			"G":           r = "6";
			"Z":           r = "2";
			default: begin
				if ((u >= "A" && u <= "Z") || (u >= "0" && u <= "9") || u == Filler) begin
					r = u;
				end else begin
					r = Filler;
				end
			end
		endcase
		return r;
	endfunction

	// Value of a corrected character, already reduced modulo 10.
	function automatic logic [3:0] char_val_mod10(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
		end else if (c >= "A" && c <= "Z") begin
			d = c - "A";
			if (d >= 8'd20) begin
				d = d - 8'd20;
			end
			if (d >= 8'd10) begin
				d = d - 8'd10;
			end
		end
		return d[3:0];
	endfunction

	// Weight of a position from its index modulo 3.
	function automatic logic [2:0] weight_of(input logic [1:0] ph);
		logic [2:0] w;
		unique case (ph)
			2'd0:    w = 3'd7;
			2'd1:    w = 3'd3;
			default: w = 3'd1;
		endcase
		return w;
	endfunction

	// Reduce a value of at most 79 modulo 10.
	function automatic logic [3:0] mod10(input logic [6:0] x);
		logic [6:0] t;
		t = x;
		if (t >= 7'd40) begin
			t = t - 7'd40;
		end
		if (t >= 7'd20) begin
			t = t - 7'd20;
		end
		if (t >= 7'd10) begin
			t = t - 7'd10;
		end
		return t[3:0];
	endfunction

endpackage
`default_nettype wire

[src/mrzv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MRZ validator front end
// Accepts characters, corrects them, tracks line and column, and tells the
// back end which sums and checks each character touches.
// ----------------------------------------------------------------------------
module mrzv_front
	import mrzv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  character,
	input  wire logic [1:0]  line_number,
	input  wire logic        record_last,
	input  wire mrzv_qstat_t qstat,
	output logic             push,
	output mrzv_cmd_t        cmd
);

	logic [1:0] cur_line_q;
	logic [4:0] column_q;
	logic [1:0] phase_q;

	logic       line_change;
	logic [4:0] pos;
	logic [1:0] ph;
	logic [1:0] ph1;
	logic       in_range;
	logic [7:0] fixed;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		line_change = (line_number != cur_line_q);
		pos         = line_change ? 5'd0 : column_q;
		ph          = line_change ? 2'd0 : phase_q;
		ph1         = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
		in_range    = (pos < 5'(LineLength));
		fixed       = fix_char(character);

		cmd          = '0;
		cmd.ch       = fixed;
		cmd.val      = char_val_mod10(fixed);
		cmd.is_digit = (fixed >= "0" && fixed <= "9");
		cmd.last     = record_last;

		if (in_range && line_number == 2'd0) begin
			if (pos >= 5'd5 && pos <= 5'd13) begin
				cmd.acc_en[FldDocument]  = 1'b1;
				cmd.acc_rst[FldDocument] = (pos == 5'd5);
				cmd.weight[FldDocument]  = weight_of(ph1);
			end
			cmd.chk[FldDocument] = (pos == 5'd14);
			if (pos >= 5'd5) begin
				cmd.acc_en[FldComposite]  = 1'b1;
				cmd.acc_rst[FldComposite] = (pos == 5'd5);
				cmd.weight[FldComposite]  = weight_of(ph1);
			end
		end else if (in_range && line_number == 2'd1) begin
			if (pos <= 5'd5) begin
				cmd.acc_en[FldBirth]  = 1'b1;
				cmd.acc_rst[FldBirth] = (pos == 5'd0);
				cmd.weight[FldBirth]  = weight_of(ph);
			end
			cmd.chk[FldBirth] = (pos == 5'd6);
			if (pos >= 5'd8 && pos <= 5'd13) begin
				cmd.acc_en[FldExpiry]  = 1'b1;
				cmd.acc_rst[FldExpiry] = (pos == 5'd8);
				cmd.weight[FldExpiry]  = weight_of(ph1);
			end
			cmd.chk[FldExpiry] = (pos == 5'd14);
			// The composite run continues from line 0 at index 25.
			if (pos <= 5'd6) begin
				cmd.acc_en[FldComposite] = 1'b1;
				cmd.weight[FldComposite] = weight_of(ph1);
			end else if ((pos >= 5'd8 && pos <= 5'd14) || (pos >= 5'd18 && pos <= 5'd28)) begin
				cmd.acc_en[FldComposite] = 1'b1;
				cmd.weight[FldComposite] = weight_of(ph);
			end
			cmd.chk[FldComposite] = (pos == 5'd29);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q <= '0;
			column_q   <= '0;
			phase_q    <= '0;
		end else if (push) begin
			if (record_last) begin
				cur_line_q <= '0;
				column_q   <= '0;
				phase_q    <= '0;
			end else begin
				cur_line_q <= line_number;
				if (in_range) begin
					column_q <= pos + 5'd1;
					phase_q  <= ph1;
				end else begin
					column_q <= pos;
					phase_q  <= ph;
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/mrzv_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MRZ validator command queue
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module mrzv_queue
	import mrzv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire mrzv_cmd_t   push_cmd,
	input  wire logic        pop,
	output mrzv_cmd_t        head,
	output mrzv_qstat_t      qstat
);

	mrzv_cmd_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/mrzv_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MRZ validator back end
// Updates the weighted sums and check flags and holds the result register.
// ----------------------------------------------------------------------------
module mrzv_back
	import mrzv_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mrzv_cmd_t    head,
	input  wire mrzv_qstat_t  qstat,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_char,
	output logic [NumFields-1:0] out_flags,
	output logic [5:0]        out_score,
	output logic              out_last
);

	logic [NumFields-1:0][3:0] sum_q;
	logic [NumFields-1:0]      flags_q;
	logic                      out_valid_q;
	logic [7:0]                out_char_q;
	logic [NumFields-1:0]      out_flags_q;
	logic [5:0]                out_score_q;
	logic                      out_last_q;

	logic [NumFields-1:0][3:0] sum_next;
	logic [NumFields-1:0]      flags_next;
	logic [3:0]                base;
	logic [2:0]                cnt;
	logic [5:0]                score_next;

	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	always_comb begin
		sum_next   = sum_q;
		flags_next = flags_q;
		base       = '0;
		for (int i = 0; i < NumFields; i++) begin
			base = head.acc_rst[i] ? 4'd0 : sum_q[i];
			if (head.acc_en[i]) begin
				sum_next[i] = mod10(7'(base) + 7'(head.val) * 7'(head.weight[i]));
			end
			if (head.chk[i]) begin
				flags_next[i] = head.is_digit && (head.val == sum_q[i]);
			end
		end
		cnt = 3'(flags_next[0]) + 3'(flags_next[1]) + 3'(flags_next[2])
			+ 3'(flags_next[3]);
		score_next = 6'(cnt) * FieldScore;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (head.last) begin
					sum_q   <= '0;
					flags_q <= '0;
				end else begin
					sum_q   <= sum_next;
					flags_q <= flags_next;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char_q  <= head.ch;
			out_flags_q <= flags_next;
			out_score_q <= score_next;
			out_last_q  <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_flags = out_flags_q;
	assign out_score = out_score_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

[src/mrz_check_digit_validator.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted character is written into the queue; from there it is loaded into
// the result register once that register is empty or its result is being taken.
// Throughput: one character per cycle while results are taken; with the output
// stalled, two requests wait in the queue and s_axis_tready drops until one moves on.
// Reset: arst_n clears line, column, sums, flags and both handshakes at once.
// Sums and flags also return to zero after each record's last character.
// ----------------------------------------------------------------------------
// MRZ check-digit validator
// Streams the characters of a three-line, 30-column identity card MRZ,
// echoes each corrected character and reports the four check-digit flags
// with a running score.
// ----------------------------------------------------------------------------
module mrz_check_digit_validator
	import mrzv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request in: one raw OCR character.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] line_number
	input  wire logic        s_axis_tlast,   // record_last
	// Request out: one result per character.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] corrected_character, [8] document_ok, [9] birth_ok,
	// [10] expiry_ok, [11] composite_ok, [17:12] total_score, [23:18] zero
	output logic [23:0]      m_axis_tdata,
	output logic             m_axis_tlast    // record_done
);

	// The front end classifies each request as it is accepted: it corrects the
	// character, follows line and column, and works out which of the four
	// weighted sums it feeds, with which weight, and whether it is a check
	// position. The queue lets the front accept up to two requests while the
	// output side is stalled; the back end applies the command to the sums
	// and flags and holds the finished result in its output register.

	mrzv_cmd_t   front_cmd;
	mrzv_cmd_t   head_cmd;
	mrzv_qstat_t qstat;
	logic        q_push;
	logic        q_pop;

	logic [7:0]           res_char;
	logic [NumFields-1:0] res_flags;
	logic [5:0]           res_score;

	mrzv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.character   (s_axis_tdata),
		.line_number (s_axis_tuser),
		.record_last (s_axis_tlast),
		.qstat       (qstat),
		.push        (q_push),
		.cmd         (front_cmd)
	);

	mrzv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.qstat    (qstat)
	);

	mrzv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_cmd),
		.qstat     (qstat),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (res_char),
		.out_flags (res_flags),
		.out_score (res_score),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, res_score, res_flags, res_char};

	// The score always matches the number of flags it reports.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[17:12] == 6'($countones(m_axis_tdata[11:8])) * FieldScore))
		else $error("score does not match flags");

	// The queue never takes a request while it is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("queue overflow");

	// Only digits, capital letters and filler are ever echoed.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[7:0] >= "0" && m_axis_tdata[7:0] <= "9")
			|| (m_axis_tdata[7:0] >= "A" && m_axis_tdata[7:0] <= "Z")
			|| (m_axis_tdata[7:0] == Filler)))
		else $error("uncorrected character echoed");

endmodule
`default_nettype wire
